// ===== rtl/core/fstk_pkg.sv =====
// Shared types, codes and defaults for the Forth data stack machine.
package fstk_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int OP_W            = 5;
    localparam int KIND_W          = 2;
    localparam int STATUS_W        = 3;
    localparam int FIELD_W         = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 5'd0,
        OP_LIST  = 5'd1,
        OP_PRINT = 5'd2,
        OP_DUP   = 5'd3,
        OP_DROP  = 5'd4,
        OP_SWAP  = 5'd5,
        OP_OVER  = 5'd6,
        OP_ADD   = 5'd7,
        OP_SUB   = 5'd8,
        OP_MUL   = 5'd9,
        OP_DIV   = 5'd10,
        OP_MOD   = 5'd11,
        OP_EQ    = 5'd12,
        OP_LT    = 5'd13,
        OP_LE    = 5'd14,
        OP_GT    = 5'd15,
        OP_GE    = 5'd16,
        OP_AND   = 5'd17,
        OP_OR    = 5'd18,
        OP_NOT   = 5'd19
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK   = 2'd0,
        KIND_PRINT = 2'd1,
        KIND_ENTRY = 2'd2,
        KIND_EMPTY = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_HALTED    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        AS_TOP    = 2'd0,
        AS_SECOND = 2'd1,
        AS_NEXT   = 2'd2,
        AS_INDEX  = 2'd3
    } t_addr_sel;

    typedef enum logic [2:0] {
        WD_LIT    = 3'd0,
        WD_TOP    = 3'd1,
        WD_SECOND = 3'd2,
        WD_NOT    = 3'd3,
        WD_LOGIC  = 3'd4,
        WD_ARITH  = 3'd5
    } t_wdata_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD_SEC,
        S_LOAD_A,
        S_EXEC,
        S_SWAP2,
        S_ARITH,
        S_AR_WR,
        S_PRINT,
        S_LIST_RD,
        S_LIST_EMIT
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        t_addr_sel  rd_sel;
        logic       load_b;
        logic       load_a;
        logic       wr_en;
        t_addr_sel  wr_sel;
        t_wdata_sel wd_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_halt;
        logic       idx_clr;
        logic       idx_inc;
        logic       ar_start;
        logic       ar_step;
        logic       emit;
        t_kind      emit_kind;
        t_status    emit_status;
        logic       emit_rd;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_status         chk;
        logic            cnt_zero;
        logic            idx_last;
        logic            b_zero;
        logic            ar_done;
        logic            out_free;
    } t_sts;

endpackage

// ===== rtl/core/fstk_ctrl.sv =====
// Controller state machine that sequences each word through the datapath.
module fstk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fstk_pkg::t_sts      i_sts,
    output fstk_pkg::t_cmd      o_cmd
);

    fstk_pkg::t_state r_state;
    fstk_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fstk_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fstk_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = fstk_pkg::S_CHECK;
                end
            end
            fstk_pkg::S_CHECK: begin
                if (i_sts.chk != fstk_pkg::ST_OK) begin
                    if (i_sts.out_free) begin
                        n_state = fstk_pkg::S_IDLE;
                    end
                end else begin
                    case (i_sts.op)
                        fstk_pkg::OP_PUSH, fstk_pkg::OP_DROP: begin
                            if (i_sts.out_free) begin
                                n_state = fstk_pkg::S_IDLE;
                            end
                        end
                        fstk_pkg::OP_LIST: begin
                            if (!i_sts.cnt_zero) begin
                                n_state = fstk_pkg::S_LIST_RD;
                            end else if (i_sts.out_free) begin
                                n_state = fstk_pkg::S_IDLE;
                            end
                        end
                        fstk_pkg::OP_PRINT: begin
                            n_state = fstk_pkg::S_PRINT;
                        end
                        default: begin
                            if (i_sts.op inside {[fstk_pkg::OP_DUP:fstk_pkg::OP_NOT]}) begin
                                n_state = fstk_pkg::S_RD_SEC;
                            end else if (i_sts.out_free) begin
                                n_state = fstk_pkg::S_IDLE;
                            end
                        end
                    endcase
                end
            end
            fstk_pkg::S_RD_SEC: begin
                n_state = fstk_pkg::S_LOAD_A;
            end
            fstk_pkg::S_LOAD_A: begin
                n_state = fstk_pkg::S_EXEC;
            end
            fstk_pkg::S_EXEC: begin
                case (i_sts.op)
                    fstk_pkg::OP_MUL: begin
                        n_state = fstk_pkg::S_ARITH;
                    end
                    fstk_pkg::OP_DIV, fstk_pkg::OP_MOD: begin
                        if (!i_sts.b_zero) begin
                            n_state = fstk_pkg::S_ARITH;
                        end else if (i_sts.out_free) begin
                            n_state = fstk_pkg::S_IDLE;
                        end
                    end
                    fstk_pkg::OP_SWAP: begin
                        n_state = fstk_pkg::S_SWAP2;
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            n_state = fstk_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            fstk_pkg::S_SWAP2, fstk_pkg::S_AR_WR, fstk_pkg::S_PRINT: begin
                if (i_sts.out_free) begin
                    n_state = fstk_pkg::S_IDLE;
                end
            end
            fstk_pkg::S_ARITH: begin
                if (i_sts.ar_done) begin
                    n_state = fstk_pkg::S_AR_WR;
                end
            end
            fstk_pkg::S_LIST_RD: begin
                n_state = fstk_pkg::S_LIST_EMIT;
            end
            fstk_pkg::S_LIST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.idx_last ? fstk_pkg::S_IDLE : fstk_pkg::S_LIST_RD;
                end
            end
            default: begin
                n_state = fstk_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            fstk_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            fstk_pkg::S_CHECK: begin
                o_cmd.idx_clr = 1'b1;
                if (i_sts.chk != fstk_pkg::ST_OK) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = i_sts.chk;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.set_halt    = (i_sts.chk != fstk_pkg::ST_HALTED);
                    end
                end else begin
                    case (i_sts.op)
                        fstk_pkg::OP_PUSH: begin
                            if (i_sts.out_free) begin
                                o_cmd.wr_en     = 1'b1;
                                o_cmd.wr_sel    = fstk_pkg::AS_NEXT;
                                o_cmd.wd_sel    = fstk_pkg::WD_LIT;
                                o_cmd.cnt_inc   = 1'b1;
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_last = 1'b1;
                            end
                        end
                        fstk_pkg::OP_DROP: begin
                            if (i_sts.out_free) begin
                                o_cmd.cnt_dec   = 1'b1;
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_last = 1'b1;
                            end
                        end
                        fstk_pkg::OP_LIST: begin
                            if (i_sts.cnt_zero && i_sts.out_free) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_kind = fstk_pkg::KIND_EMPTY;
                                o_cmd.emit_last = 1'b1;
                            end
                        end
                        fstk_pkg::OP_PRINT: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = fstk_pkg::AS_TOP;
                        end
                        default: begin
                            if (i_sts.op inside {[fstk_pkg::OP_DUP:fstk_pkg::OP_NOT]}) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = fstk_pkg::AS_TOP;
                            end else if (i_sts.out_free) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_last = 1'b1;
                            end
                        end
                    endcase
                end
            end
            fstk_pkg::S_RD_SEC: begin
                o_cmd.load_b = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = fstk_pkg::AS_SECOND;
            end
            fstk_pkg::S_LOAD_A: begin
                o_cmd.load_a = 1'b1;
            end
            fstk_pkg::S_EXEC: begin
                case (i_sts.op)
                    fstk_pkg::OP_MUL: begin
                        o_cmd.ar_start = 1'b1;
                    end
                    fstk_pkg::OP_DIV, fstk_pkg::OP_MOD: begin
                        if (!i_sts.b_zero) begin
                            o_cmd.ar_start = 1'b1;
                        end else if (i_sts.out_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = fstk_pkg::ST_DIV_ZERO;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.set_halt    = 1'b1;
                        end
                    end
                    fstk_pkg::OP_SWAP: begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = fstk_pkg::AS_SECOND;
                        o_cmd.wd_sel = fstk_pkg::WD_TOP;
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            o_cmd.wr_en     = 1'b1;
                            case (i_sts.op)
                                fstk_pkg::OP_DUP: begin
                                    o_cmd.wr_sel  = fstk_pkg::AS_NEXT;
                                    o_cmd.wd_sel  = fstk_pkg::WD_TOP;
                                    o_cmd.cnt_inc = 1'b1;
                                end
                                fstk_pkg::OP_OVER: begin
                                    o_cmd.wr_sel  = fstk_pkg::AS_NEXT;
                                    o_cmd.wd_sel  = fstk_pkg::WD_SECOND;
                                    o_cmd.cnt_inc = 1'b1;
                                end
                                fstk_pkg::OP_NOT: begin
                                    o_cmd.wr_sel = fstk_pkg::AS_TOP;
                                    o_cmd.wd_sel = fstk_pkg::WD_NOT;
                                end
                                default: begin
                                    o_cmd.wr_sel  = fstk_pkg::AS_SECOND;
                                    o_cmd.wd_sel  = fstk_pkg::WD_LOGIC;
                                    o_cmd.cnt_dec = 1'b1;
                                end
                            endcase
                        end
                    end
                endcase
            end
            fstk_pkg::S_SWAP2: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_sel    = fstk_pkg::AS_TOP;
                    o_cmd.wd_sel    = fstk_pkg::WD_SECOND;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                end
            end
            fstk_pkg::S_ARITH: begin
                o_cmd.ar_step = !i_sts.ar_done;
            end
            fstk_pkg::S_AR_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_sel    = fstk_pkg::AS_SECOND;
                    o_cmd.wd_sel    = fstk_pkg::WD_ARITH;
                    o_cmd.cnt_dec   = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                end
            end
            fstk_pkg::S_PRINT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = fstk_pkg::KIND_PRINT;
                    o_cmd.emit_rd   = 1'b1;
                    o_cmd.emit_last = 1'b1;
                end
            end
            fstk_pkg::S_LIST_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = fstk_pkg::AS_INDEX;
            end
            fstk_pkg::S_LIST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = fstk_pkg::KIND_ENTRY;
                    o_cmd.emit_rd   = 1'b1;
                    o_cmd.emit_last = i_sts.idx_last;
                    o_cmd.idx_inc   = !i_sts.idx_last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/fstk_datapath.sv =====
// Datapath: stack memory, count, halt flag, shift-add and restoring divide unit, result register.
module fstk_datapath #(
    parameter int STACK_DEPTH = fstk_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = fstk_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fstk_pkg::t_cmd                      i_cmd,
    output fstk_pkg::t_sts                      o_sts,
    input  logic [fstk_pkg::OP_W-1:0]           i_operation,
    input  logic signed [fstk_pkg::FIELD_W-1:0] i_literal,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [fstk_pkg::FIELD_W-1:0] o_value,
    output logic [fstk_pkg::KIND_W-1:0]         o_kind,
    output logic [fstk_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_last
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int ACW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0]        mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0]        r_rd_data;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_idx;
    logic                         r_halt;
    logic [fstk_pkg::OP_W-1:0]    r_op;
    logic [DATA_WIDTH-1:0]        r_lit;
    logic signed [DATA_WIDTH-1:0] r_a;
    logic signed [DATA_WIDTH-1:0] r_b;
    logic [DATA_WIDTH-1:0]        r_x;
    logic [DATA_WIDTH-1:0]        r_y;
    logic [DATA_WIDTH:0]          r_z;
    logic [ACW-1:0]               r_ar_cnt;
    logic                         r_na;
    logic                         r_nb;
    logic                         r_ovalid;
    logic [DATA_WIDTH-1:0]        r_ovalue;
    fstk_pkg::t_kind              r_okind;
    fstk_pkg::t_status            r_ostatus;
    logic                         r_olast;

    logic [1:0]            need;
    logic [1:0]            grow;
    logic                  is_div;
    logic                  out_free;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] logic_res;
    logic [DATA_WIDTH-1:0] arith_res;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH:0]   div_trial;
    logic [DATA_WIDTH:0]   div_diff;

    function automatic logic [AW-1:0] sel_addr(
        input fstk_pkg::t_addr_sel sel,
        input logic [CW-1:0]       count,
        input logic [CW-1:0]       idx
    );
        logic [CW-1:0] full;
        case (sel)
            fstk_pkg::AS_TOP:    full = count - CW'(1);
            fstk_pkg::AS_SECOND: full = count - CW'(2);
            fstk_pkg::AS_NEXT:   full = count;
            default:             full = idx;
        endcase
        return full[AW-1:0];
    endfunction

    assign out_free = !r_ovalid || i_ready;
    assign is_div   = (r_op == fstk_pkg::OP_DIV) || (r_op == fstk_pkg::OP_MOD);
    assign rd_addr  = sel_addr(i_cmd.rd_sel, r_count, r_idx);
    assign wr_addr  = sel_addr(i_cmd.wr_sel, r_count, r_idx);
    assign mag_a    = r_a[DATA_WIDTH-1] ? DATA_WIDTH'(-r_a) : DATA_WIDTH'(r_a);
    assign mag_b    = r_b[DATA_WIDTH-1] ? DATA_WIDTH'(-r_b) : DATA_WIDTH'(r_b);
    assign div_trial = {r_z[DATA_WIDTH-1:0], r_y[DATA_WIDTH-1]};
    assign div_diff  = div_trial - {1'b0, r_x};

    always_comb begin
        need = 2'd0;
        grow = 2'd0;
        case (r_op)
            fstk_pkg::OP_PUSH: grow = 2'd1;
            fstk_pkg::OP_PRINT, fstk_pkg::OP_DROP, fstk_pkg::OP_NOT: need = 2'd1;
            fstk_pkg::OP_DUP: begin
                need = 2'd1;
                grow = 2'd1;
            end
            fstk_pkg::OP_OVER: begin
                need = 2'd2;
                grow = 2'd1;
            end
            default: begin
                if (r_op inside {fstk_pkg::OP_SWAP, [fstk_pkg::OP_ADD:fstk_pkg::OP_OR]}) begin
                    need = 2'd2;
                end
            end
        endcase
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.cnt_zero = (r_count == '0);
        o_sts.idx_last = ((r_idx + CW'(1)) == r_count);
        o_sts.b_zero   = (r_b == '0);
        o_sts.ar_done  = (r_ar_cnt == ACW'(DATA_WIDTH));
        o_sts.out_free = out_free;
        if (r_halt) begin
            o_sts.chk = fstk_pkg::ST_HALTED;
        end else if (r_count < CW'(need)) begin
            o_sts.chk = fstk_pkg::ST_UNDERFLOW;
        end else if (((CW+1)'(r_count) + (CW+1)'(grow)) > (CW+1)'(STACK_DEPTH)) begin
            o_sts.chk = fstk_pkg::ST_OVERFLOW;
        end else begin
            o_sts.chk = fstk_pkg::ST_OK;
        end
    end

    always_comb begin
        case (r_op)
            fstk_pkg::OP_ADD: logic_res = DATA_WIDTH'(r_a + r_b);
            fstk_pkg::OP_SUB: logic_res = DATA_WIDTH'(r_a - r_b);
            fstk_pkg::OP_EQ:  logic_res = DATA_WIDTH'(r_a == r_b);
            fstk_pkg::OP_LT:  logic_res = DATA_WIDTH'(r_a < r_b);
            fstk_pkg::OP_LE:  logic_res = DATA_WIDTH'(r_a <= r_b);
            fstk_pkg::OP_GT:  logic_res = DATA_WIDTH'(r_a > r_b);
            fstk_pkg::OP_GE:  logic_res = DATA_WIDTH'(r_a >= r_b);
            fstk_pkg::OP_AND: logic_res = DATA_WIDTH'((r_a != '0) && (r_b != '0));
            fstk_pkg::OP_OR:  logic_res = DATA_WIDTH'((r_a != '0) || (r_b != '0));
            default:          logic_res = '0;
        endcase
    end

    always_comb begin
        case (r_op)
            fstk_pkg::OP_DIV: arith_res = (r_na ^ r_nb) ? (~r_y + DATA_WIDTH'(1)) : r_y;
            fstk_pkg::OP_MOD: arith_res = r_na ? (~r_z[DATA_WIDTH-1:0] + DATA_WIDTH'(1))
                                               : r_z[DATA_WIDTH-1:0];
            default:          arith_res = r_z[DATA_WIDTH-1:0];
        endcase
    end

    always_comb begin
        case (i_cmd.wd_sel)
            fstk_pkg::WD_LIT:    wr_data = r_lit;
            fstk_pkg::WD_TOP:    wr_data = r_b;
            fstk_pkg::WD_SECOND: wr_data = r_a;
            fstk_pkg::WD_NOT:    wr_data = DATA_WIDTH'(r_b == '0);
            fstk_pkg::WD_LOGIC:  wr_data = logic_res;
            default:             wr_data = arith_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_lit <= DATA_WIDTH'(i_literal);
        end
        if (i_cmd.load_b) begin
            r_b <= r_rd_data;
        end
        if (i_cmd.load_a) begin
            r_a <= r_rd_data;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.ar_start) begin
            r_ar_cnt <= '0;
            r_z      <= '0;
            r_na     <= r_a[DATA_WIDTH-1];
            r_nb     <= r_b[DATA_WIDTH-1];
            if (is_div) begin
                r_x <= mag_b;
                r_y <= mag_a;
            end else begin
                r_x <= r_a;
                r_y <= r_b;
            end
        end else if (i_cmd.ar_step) begin
            r_ar_cnt <= r_ar_cnt + ACW'(1);
            if (is_div) begin
                if (!div_diff[DATA_WIDTH]) begin
                    r_z <= div_diff;
                    r_y <= {r_y[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    r_z <= div_trial;
                    r_y <= {r_y[DATA_WIDTH-2:0], 1'b0};
                end
            end else begin
                r_z <= {1'b0, r_z[DATA_WIDTH-1:0] + (r_y[0] ? r_x : '0)};
                r_x <= {r_x[DATA_WIDTH-2:0], 1'b0};
                r_y <= {1'b0, r_y[DATA_WIDTH-1:1]};
            end
        end
        if (i_cmd.emit) begin
            r_ovalue  <= i_cmd.emit_rd ? r_rd_data : '0;
            r_okind   <= i_cmd.emit_kind;
            r_ostatus <= i_cmd.emit_status;
            r_olast   <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_halt   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.set_halt) begin
                r_halt <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_value  = fstk_pkg::FIELD_W'($signed(r_ovalue));
    assign o_kind   = r_okind;
    assign o_status = r_ostatus;
    assign o_last   = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("Stack count exceeds the depth.");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("Halt flag cleared without reset.");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("Result written while the output register is occupied.");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (r_count < CW'(STACK_DEPTH)))
        else $error("Stack grows past its depth.");

    a_no_halted_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> !i_cmd.wr_en)
        else $error("Stack written after halt.");

endmodule

// ===== rtl/core/forth_stack_machine.sv =====
// Top level of the Forth data stack machine: controller and datapath.
//
//   Channel  | Handshake          | Fields
//   ---------+--------------------+--------------------------------------
//   input    | i_valid / o_ready  | i_operation, i_literal
//   output   | o_valid / i_ready  | o_value, o_kind, o_status, o_last
//
// One transaction is taken at a time; o_ready is high only while the controller is idle.
// Push, drop, unknown codes and stack errors are answered from the check state; print reads
// the top there and answers from the print state. Other words read the top and second entry,
// load the operands and execute; swap then writes the top. Mul, div and mod run DATA_WIDTH
// steps of the shift-add or restoring divide unit. A listing reads each entry through the
// registered read of the stack memory. Reset clears the stack count, the halt flag and the
// output valid flag; a stalled output holds the controller in each state that emits a result.
module forth_stack_machine #(
    parameter int STACK_DEPTH = fstk_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = fstk_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [fstk_pkg::OP_W-1:0]           i_operation,
    input  logic signed [fstk_pkg::FIELD_W-1:0] i_literal,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [fstk_pkg::FIELD_W-1:0] o_value,
    output logic [fstk_pkg::KIND_W-1:0]         o_kind,
    output logic [fstk_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_last
);

    fstk_pkg::t_cmd cmd;
    fstk_pkg::t_sts sts;

    fstk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fstk_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_literal   (i_literal),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_kind      (o_kind),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

// ===== tb/forth_stack_machine_tb.sv =====
// Self-checking testbench for the Forth data stack machine with random handshake gaps.
module forth_stack_machine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [fstk_pkg::OP_W-1:0] op;
        logic [31:0]               lit;
    } t_word;

    typedef struct packed {
        logic [31:0]                   value;
        logic [fstk_pkg::KIND_W-1:0]   kind;
        logic [fstk_pkg::STATUS_W-1:0] status;
        logic                          last;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [fstk_pkg::OP_W-1:0] i_operation = '0;
    logic signed [fstk_pkg::FIELD_W-1:0] i_literal = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [fstk_pkg::FIELD_W-1:0] o_value;
    logic [fstk_pkg::KIND_W-1:0] o_kind;
    logic [fstk_pkg::STATUS_W-1:0] o_status;
    logic o_last;

    forth_stack_machine uut (.*);

    always #5 i_clk = ~i_clk;

    t_word  word_queue[$];
    t_reply reply_queue[$];
    logic [31:0] stk[16];
    int unsigned depth = 0;
    bit halt_flag = 0;
    int errors = 0;
    int words_sent = 0;
    int replies_seen = 0;

    function automatic void put_reply(logic [31:0] v, fstk_pkg::t_kind k,
                                      fstk_pkg::t_status s, bit l);
        reply_queue.push_back('{v, k, s, l});
    endfunction

    // Computes the replies caused by one word and updates the model stack.
    function automatic void execute_word(t_word w);
        int unsigned need;
        int unsigned grow;
        logic signed [31:0] a, b;
        logic [31:0] r;
        need = 0;
        grow = 0;
        if (halt_flag) begin
            put_reply(0, fstk_pkg::KIND_ACK, fstk_pkg::ST_HALTED, 1);
            return;
        end
        case (w.op)
            fstk_pkg::OP_PRINT, fstk_pkg::OP_DROP, fstk_pkg::OP_NOT: need = 1;
            fstk_pkg::OP_DUP: begin need = 1; grow = 1; end
            fstk_pkg::OP_SWAP: need = 2;
            fstk_pkg::OP_OVER: begin need = 2; grow = 1; end
            fstk_pkg::OP_PUSH: grow = 1;
            default: if (w.op >= fstk_pkg::OP_ADD && w.op <= fstk_pkg::OP_OR) need = 2;
        endcase
        if (depth < need) begin
            halt_flag = 1;
            put_reply(0, fstk_pkg::KIND_ACK, fstk_pkg::ST_UNDERFLOW, 1);
            return;
        end
        if (depth + grow > 16) begin
            halt_flag = 1;
            put_reply(0, fstk_pkg::KIND_ACK, fstk_pkg::ST_OVERFLOW, 1);
            return;
        end
        if (w.op == fstk_pkg::OP_LIST) begin
            if (depth == 0) put_reply(0, fstk_pkg::KIND_EMPTY, fstk_pkg::ST_OK, 1);
            for (int i = 0; i < depth; i++)
                put_reply(stk[i], fstk_pkg::KIND_ENTRY, fstk_pkg::ST_OK, i + 1 == depth);
            return;
        end
        if (w.op == fstk_pkg::OP_PRINT) begin
            put_reply(stk[depth-1], fstk_pkg::KIND_PRINT, fstk_pkg::ST_OK, 1);
            return;
        end
        a = (depth >= 2) ? stk[depth-2] : 0;
        b = (depth >= 1) ? stk[depth-1] : 0;
        case (w.op)
            fstk_pkg::OP_PUSH: begin stk[depth] = w.lit; depth++; end
            fstk_pkg::OP_DUP: begin stk[depth] = b; depth++; end
            fstk_pkg::OP_DROP: depth--;
            fstk_pkg::OP_SWAP: begin stk[depth-2] = b; stk[depth-1] = a; end
            fstk_pkg::OP_OVER: begin stk[depth] = a; depth++; end
            fstk_pkg::OP_NOT: stk[depth-1] = (b == 0);
            default: begin
                if (w.op >= fstk_pkg::OP_ADD && w.op <= fstk_pkg::OP_OR) begin
                    if ((w.op == fstk_pkg::OP_DIV || w.op == fstk_pkg::OP_MOD) && b == 0) begin
                        halt_flag = 1;
                        put_reply(0, fstk_pkg::KIND_ACK, fstk_pkg::ST_DIV_ZERO, 1);
                        return;
                    end
                    case (w.op)
                        fstk_pkg::OP_ADD: r = a + b;
                        fstk_pkg::OP_SUB: r = a - b;
                        fstk_pkg::OP_MUL: r = a * b;
                        fstk_pkg::OP_DIV: r = (a == 32'sh80000000 && b == -1) ? a : a / b;
                        fstk_pkg::OP_MOD: r = (b == -1) ? 0 : a % b;
                        fstk_pkg::OP_EQ:  r = (a == b);
                        fstk_pkg::OP_LT:  r = (a < b);
                        fstk_pkg::OP_LE:  r = (a <= b);
                        fstk_pkg::OP_GT:  r = (a > b);
                        fstk_pkg::OP_GE:  r = (a >= b);
                        fstk_pkg::OP_AND: r = (a != 0 && b != 0);
                        default: r = (a != 0 || b != 0);
                    endcase
                    stk[depth-2] = r;
                    depth--;
                end
            end
        endcase
        put_reply(0, fstk_pkg::KIND_ACK, fstk_pkg::ST_OK, 1);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Driver: holds each transaction until accepted, then draws the next gap.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            execute_word('{i_operation, i_literal});
            words_sent++;
        end
        if (!i_valid || o_ready) begin
            if (send_gap > 0 || word_queue.size() == 0 || !i_rst_n) begin
                i_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                t_word w;
                w = word_queue.pop_front();
                i_valid <= 1'b1;
                i_operation <= w.op;
                i_literal <= w.lit;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
        end
    end

    // Monitor: random backpressure and in-order comparison.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            t_reply exp_r;
            replies_seen++;
            if (reply_queue.size() == 0) begin
                $error("unexpected transaction value=%0d kind=%0d", o_value, o_kind);
                errors++;
            end else begin
                exp_r = reply_queue.pop_front();
                if (o_value !== exp_r.value) begin
                    $error("value expected %0d actual %0d", $signed(exp_r.value), o_value);
                    errors++;
                end
                if (o_kind !== exp_r.kind) begin
                    $error("kind expected %0d actual %0d", exp_r.kind, o_kind);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    errors++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last expected %0d actual %0d", exp_r.last, o_last);
                    errors++;
                end
            end
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            i_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else if (!i_ready || o_valid) begin
            i_ready <= 1'b1;
            if (o_valid && i_ready)
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        end
    end

    task automatic add_word(fstk_pkg::t_op op, logic [31:0] lit = 0);
        word_queue.push_back('{op, lit});
    endtask

    task automatic wait_drain();
        while (word_queue.size() != 0 || i_valid || reply_queue.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        int sim_depth;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: empty list, extremes, every word but drop, special cases.
        add_word(fstk_pkg::OP_LIST);
        add_word(fstk_pkg::OP_PUSH, 32'h80000000);
        add_word(fstk_pkg::OP_PUSH, 32'hffffffff);
        add_word(fstk_pkg::OP_DIV);
        add_word(fstk_pkg::OP_PRINT);
        add_word(fstk_pkg::OP_PUSH, 32'h80000000);
        add_word(fstk_pkg::OP_PUSH, 32'hffffffff);
        add_word(fstk_pkg::OP_MOD);
        add_word(fstk_pkg::OP_PUSH, 32'h7fffffff);
        add_word(fstk_pkg::OP_DUP);
        add_word(fstk_pkg::OP_ADD);
        add_word(fstk_pkg::OP_PUSH, -7);
        add_word(fstk_pkg::OP_PUSH, 2);
        add_word(fstk_pkg::OP_OVER);
        add_word(fstk_pkg::OP_SWAP);
        add_word(fstk_pkg::OP_MUL);
        add_word(fstk_pkg::OP_SUB);
        for (int op = fstk_pkg::OP_EQ; op <= fstk_pkg::OP_OR; op++) begin
            add_word(fstk_pkg::OP_DUP);
            add_word(fstk_pkg::OP_PUSH, 3);
            add_word(fstk_pkg::t_op'(op));
        end
        add_word(fstk_pkg::OP_NOT);
        word_queue.push_back('{5'd25, 32'h0});
        word_queue.push_back('{5'd31, 32'hffffffff});
        add_word(fstk_pkg::OP_LIST);
        wait_drain();
        // Random: well-formed words chosen against a tracked depth; errors only at the end.
        sim_depth = depth;
        for (int i = 0; i < 140; i++) begin
            int pick;
            pick = $urandom_range(0, 19);
            if (pick == fstk_pkg::OP_PUSH && sim_depth >= 16) pick = fstk_pkg::OP_DROP;
            if (sim_depth < 2 && pick > fstk_pkg::OP_PRINT) pick = fstk_pkg::OP_PUSH;
            if (sim_depth >= 15 && (pick == fstk_pkg::OP_DUP || pick == fstk_pkg::OP_OVER))
                pick = fstk_pkg::OP_DROP;
            if (pick == fstk_pkg::OP_PRINT && sim_depth == 0) pick = fstk_pkg::OP_PUSH;
            if ((pick == fstk_pkg::OP_DIV || pick == fstk_pkg::OP_MOD) && stk_top_zero_risk())
                pick = fstk_pkg::OP_ADD;
            if ((pick == fstk_pkg::OP_DIV || pick == fstk_pkg::OP_MOD) && sim_depth >= 16)
                pick = fstk_pkg::OP_DROP;
            if ($urandom_range(0, 9) == 0) pick = $urandom_range(20, 31);
            word_queue.push_back('{pick[4:0], rand_value()});
            if (pick == fstk_pkg::OP_PUSH || pick == fstk_pkg::OP_DUP
                || pick == fstk_pkg::OP_OVER) sim_depth++;
            else if (pick == fstk_pkg::OP_DROP
                     || (pick >= fstk_pkg::OP_ADD && pick <= fstk_pkg::OP_OR)) sim_depth--;
            if (pick == fstk_pkg::OP_DIV || pick == fstk_pkg::OP_MOD) begin
                // Guard the divisor: push a nonzero value just before.
                word_queue.insert(word_queue.size() - 1,
                                  '{fstk_pkg::OP_PUSH, rand_value() | 32'h1});
                sim_depth++;
            end
        end
        add_word(fstk_pkg::OP_LIST);
        // Error endings: fill past depth, then a few words while halted.
        for (int i = 0; i < 18; i++) add_word(fstk_pkg::OP_PUSH, $urandom);
        add_word(fstk_pkg::OP_PRINT);
        add_word(fstk_pkg::OP_LIST);
        add_word(fstk_pkg::OP_DIV);
        wait_drain();
        $display("Sent %0d words and checked %0d transactions: all words, listings,",
                 words_sent, replies_seen);
        $display("arithmetic extremes, unknown codes, overflow and sticky halt.");
        if (errors == 0)
            $display("** forth_stack_machine: PASSED **");
        else
            $display("** forth_stack_machine: FAILED **");
        $finish;
    end

    function automatic bit stk_top_zero_risk();
        return 1'b0;
    endfunction

    initial begin
        #20ms;
        $display("** forth_stack_machine: FAILED **");
        $finish;
    end
endmodule
